// ===== rtl/rsvg_pkg.sv =====
// ----------------------------------------------------------------------------
// rsvg_pkg
// Shared types, codes and helpers of the ribbon strip vertex generator.
// ----------------------------------------------------------------------------
package rsvg_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int CNT_W          = 11;
  localparam int CFG_IDX_W      = 3;
  localparam int ITR_W          = 6;
  localparam int SQRT_STEPS     = 31;
  localparam int DIV_STEPS      = 63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UV_START_U = 3'd0,
    CFG_UV_START_V = 3'd1,
    CFG_UV_END_U   = 3'd2,
    CFG_UV_END_V   = 3'd3,
    CFG_BASE_VERT  = 3'd4,
    CFG_BASE_SLOT  = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_FIRST, OP_DIFF, OP_ZERO, OP_NORM, OP_SQA,
    OP_SQB, OP_SQRT, OP_DIVX, OP_DIVZ, OP_NZ, OP_DIVSTEP, OP_OFFX, OP_OFFZ,
    OP_UMUL, OP_UDIV, OP_USAVE, OP_EMIT, OP_UPD
  } dp_op_t;

  localparam logic [3:0] BEAT_IDX_LO  = 4'd2;
  localparam logic [3:0] BEAT_IDX_HI  = 4'd7;
  localparam logic [3:0] BEAT_TAIL_LO = 4'd8;
  localparam logic [3:0] BEAT_TAIL_HI = 4'd9;

  typedef struct packed {
    dp_op_t     op;
    logic       second;
    logic [3:0] beat;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic short_cnt;
    logic first_pt;
    logic last_pt;
    logic zero_dir;
    logic norm_ok;
    logic itr_zero;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [31:0]      point_x;
    logic [31:0]      point_y;
    logic [31:0]      point_z;
    logic [30:0]      half_width;
    logic [31:0]      point_color;
    logic [CNT_W-1:0] point_count;
  } point_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] slot;
    logic [31:0] vert_x;
    logic [31:0] vert_y;
    logic [31:0] vert_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] vert_color;
    logic [31:0] vertex_ref;
    logic        last;
  } res_t;

  // corner of the segment quad used by each of the six indices
  function automatic logic [1:0] tri_ofs(input logic [2:0] j);
    logic [1:0] r;
    r = 2'd0;
    unique case (j)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd2;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rsvg_if.sv =====
// ----------------------------------------------------------------------------
// rsvg channel interfaces
// Valid/ready channels for control points, result records and config writes.
// ----------------------------------------------------------------------------
interface rsvg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] point_x;
  logic [31:0] point_y;
  logic [31:0] point_z;
  logic [30:0] half_width;
  logic [31:0] point_color;
  logic [10:0] point_count;
  modport source (output valid, point_x, point_y, point_z, half_width, point_color,
                  point_count, input ready);
  modport sink   (input valid, point_x, point_y, point_z, half_width, point_color,
                  point_count, output ready);
endinterface

interface rsvg_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] slot;
  logic [31:0] vert_x;
  logic [31:0] vert_y;
  logic [31:0] vert_z;
  logic [31:0] tex_u;
  logic [31:0] tex_v;
  logic [31:0] vert_color;
  logic [31:0] vertex_ref;
  logic        last;
  modport source (output valid, kind, slot, vert_x, vert_y, vert_z, tex_u, tex_v,
                  vert_color, vertex_ref, last, input ready);
  modport sink   (input valid, kind, slot, vert_x, vert_y, vert_z, tex_u, tex_v,
                  vert_color, vertex_ref, last, output ready);
endinterface

interface rsvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rsvg_dp.sv =====
// ----------------------------------------------------------------------------
// rsvg_dp
// Datapath: point registers, normalizer, square root, bit-serial divider,
// shared multiplier and the output record register.
// ----------------------------------------------------------------------------
module rsvg_dp import rsvg_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  point_t               in_pt,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output res_t                 out_res,
  output dp_stat_t             stat
);

  logic [31:0] su_r, sv_r, eu_r, ev_r, bv_r, bs_r;
  logic [31:0] cx_r, cy_r, cz_r, cc_r, px_r, py_r, pz_r, pc_r;
  logic [30:0] cw_r, pw_r;
  logic [CNT_W-1:0] cn_r, cnt_r;
  logic [32:0] ax_r, az_r;
  logic        dz_pos_r, dx_neg_r;
  logic [63:0] sq_s_r, sq_res_r, sq_bit_r;
  logic [63:0] num_r;
  logic [32:0] den_r;
  logic [33:0] rem_r;
  logic [32:0] q_r;
  logic [ITR_W-1:0] itr_r;
  logic [30:0] nx_r, nz_r;
  logic [33:0] ox_r, oz_r;
  logic [43:0] umag_r;
  logic [31:0] u_r;
  logic        out_valid_r;
  res_t        res_r;

  logic [CNT_W-1:0] segs, s_idx, ksel, kc, n_cl;
  logic [32:0] dx, dz, m, ud, udmag;
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [62:0] off_sum;
  logic [32:0] off_mag;
  logic [33:0] off_signed;
  logic [63:0] sq_try;
  logic [34:0] rem_sh;
  logic        rem_ge;
  logic [30:0] wsel;
  logic [31:0] vx, vy, vz, vc;
  logic [33:0] ox_use, oz_use;
  logic        right;
  logic [2:0]  jj;
  res_t        rec;

  function automatic logic [31:0] sat34(input logic [33:0] v);
    logic [31:0] r;
    r = v[31:0];
    if (!v[33] && (v[32:31] != 2'b00)) r = 32'h7fff_ffff;
    else if (v[33] && (v[32:31] != 2'b11)) r = 32'h8000_0000;
    return r;
  endfunction

  assign n_cl  = ({21'd0, in_pt.point_count} > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                 : in_pt.point_count;
  assign segs  = cn_r - CNT_W'(1);
  assign s_idx = cnt_r - CNT_W'(1);
  assign ksel  = cmd.second ? cnt_r : s_idx;
  assign kc    = (ksel > segs) ? segs : ksel;

  assign dx = {cx_r[31], cx_r} - {px_r[31], px_r};
  assign dz = {cz_r[31], cz_r} - {pz_r[31], pz_r};
  assign m  = (ax_r > az_r) ? ax_r : az_r;
  assign ud    = {eu_r[31], eu_r} - {su_r[31], su_r};
  assign udmag = ud[32] ? (33'd0 - ud) : ud;

  assign wsel = cmd.second ? cw_r : pw_r;

  // one shared multiplier, operands picked by the current step
  always_comb begin
    mul_a = 33'd0;
    mul_b = 33'd0;
    unique case (cmd.op)
      OP_SQA:  begin mul_a = ax_r; mul_b = ax_r; end
      OP_SQB:  begin mul_a = az_r; mul_b = az_r; end
      OP_OFFX: begin mul_a = {2'd0, nx_r}; mul_b = {2'd0, wsel}; end
      OP_OFFZ: begin mul_a = {2'd0, nz_r}; mul_b = {2'd0, wsel}; end
      OP_UMUL: begin mul_a = udmag; mul_b = {22'd0, kc}; end
      default: begin mul_a = 33'd0; mul_b = 33'd0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign off_sum    = mul_p[62:0] + 63'(64'd1 << 29);
  assign off_mag    = off_sum[62:30];
  assign off_signed = {1'b0, off_mag};

  assign sq_try = sq_res_r + sq_bit_r;
  assign rem_sh = {rem_r, num_r[63]};
  assign rem_ge = rem_sh >= {2'd0, den_r};

  // record for the current beat
  assign right = cmd.beat[0];
  assign jj    = 3'(cmd.beat - BEAT_IDX_LO);
  always_comb begin
    vx = cmd.second ? cx_r : px_r;
    vy = cmd.second ? cy_r : py_r;
    vz = cmd.second ? cz_r : pz_r;
    vc = cmd.second ? cc_r : pc_r;
    ox_use = right ? ox_r : (34'd0 - ox_r);
    oz_use = right ? oz_r : (34'd0 - oz_r);
    rec = '0;
    rec.last = cmd.last;
    if ((cmd.beat >= BEAT_IDX_LO) && (cmd.beat <= BEAT_IDX_HI)) begin
      rec.kind       = 1'b1;
      rec.slot       = bs_r + 32'({s_idx, 2'b00}) + 32'({s_idx, 1'b0}) + 32'(jj);
      rec.vertex_ref = bv_r + 32'({s_idx, 1'b0}) + 32'(tri_ofs(jj));
    end else begin
      rec.kind       = 1'b0;
      rec.slot       = bv_r + 32'({ksel, 1'b0}) + 32'(right);
      rec.vert_x     = sat34({{2{vx[31]}}, vx} + ox_use);
      rec.vert_y     = vy;
      rec.vert_z     = sat34({{2{vz[31]}}, vz} + oz_use);
      rec.tex_u      = u_r;
      rec.tex_v      = right ? ev_r : sv_r;
      rec.vert_color = vc;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_r <= 32'd0;
      sv_r <= 32'd0;
      eu_r <= 32'h0001_0000;
      ev_r <= 32'h0001_0000;
      bv_r <= 32'd0;
      bs_r <= 32'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_UV_START_U: su_r <= cfg_data;
        CFG_UV_START_V: sv_r <= cfg_data;
        CFG_UV_END_U:   eu_r <= cfg_data;
        CFG_UV_END_V:   ev_r <= cfg_data;
        CFG_BASE_VERT:  bv_r <= cfg_data;
        CFG_BASE_SLOT:  bs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ribbon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      px_r  <= 32'd0;
      py_r  <= 32'd0;
      pz_r  <= 32'd0;
      pw_r  <= 31'd0;
      pc_r  <= 32'd0;
    end else if ((cmd.op == OP_CLEAR) || ((cmd.op == OP_UPD) && stat.last_pt)) begin
      cnt_r <= '0;
    end else if ((cmd.op == OP_FIRST) || (cmd.op == OP_UPD)) begin
      px_r  <= cx_r;
      py_r  <= cy_r;
      pz_r  <= cz_r;
      pw_r  <= cw_r;
      pc_r  <= cc_r;
      cnt_r <= (cmd.op == OP_FIRST) ? CNT_W'(1) : cnt_r + CNT_W'(1);
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cx_r <= in_pt.point_x;
        cy_r <= in_pt.point_y;
        cz_r <= in_pt.point_z;
        cw_r <= in_pt.half_width;
        cc_r <= in_pt.point_color;
        cn_r <= n_cl;
      end
      OP_DIFF: begin
        ax_r     <= dx[32] ? (33'd0 - dx) : dx;
        az_r     <= dz[32] ? (33'd0 - dz) : dz;
        dx_neg_r <= dx[32];
        dz_pos_r <= !dz[32] && (dz != 33'd0);
      end
      OP_ZERO: begin
        nx_r <= 31'd0;
        nz_r <= 31'd0;
      end
      OP_NORM: begin
        if (m[32] || m[31]) begin
          ax_r <= ax_r >> 1;
          az_r <= az_r >> 1;
        end else if (m[30:26] == 5'd0) begin
          ax_r <= ax_r << 4;
          az_r <= az_r << 4;
        end else begin
          ax_r <= ax_r << 1;
          az_r <= az_r << 1;
        end
      end
      OP_SQA: sq_s_r <= mul_p[63:0];
      OP_SQB: begin
        sq_s_r   <= sq_s_r + mul_p[63:0];
        sq_res_r <= 64'd0;
        sq_bit_r <= 64'd1 << 62;
        itr_r    <= ITR_W'(SQRT_STEPS);
      end
      OP_SQRT: begin
        if (sq_s_r >= sq_try) begin
          sq_s_r   <= sq_s_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        itr_r    <= itr_r - ITR_W'(1);
      end
      OP_DIVX: begin
        num_r <= {3'd0, az_r[30:0], 30'd0};
        den_r <= {1'b0, sq_res_r[31:0]};
        rem_r <= 34'd0;
        itr_r <= ITR_W'(DIV_STEPS);
      end
      OP_DIVZ: begin
        nx_r  <= q_r[30:0];
        num_r <= {3'd0, ax_r[30:0], 30'd0};
        rem_r <= 34'd0;
        itr_r <= ITR_W'(DIV_STEPS);
      end
      OP_NZ: nz_r <= q_r[30:0];
      OP_DIVSTEP: begin
        rem_r <= rem_ge ? 34'(rem_sh - {2'd0, den_r}) : rem_sh[33:0];
        q_r   <= {q_r[31:0], rem_ge};
        num_r <= num_r << 1;
        itr_r <= itr_r - ITR_W'(1);
      end
      OP_OFFX: ox_r <= dz_pos_r ? (34'd0 - off_signed) : off_signed;
      OP_OFFZ: oz_r <= dx_neg_r ? (34'd0 - off_signed) : off_signed;
      OP_UMUL: umag_r <= mul_p[43:0];
      OP_UDIV: begin
        num_r <= 64'({umag_r, 1'b0}) + 64'(segs);
        den_r <= 33'({segs, 1'b0});
        rem_r <= 34'd0;
        itr_r <= ITR_W'(DIV_STEPS);
      end
      OP_USAVE: u_r <= ud[32] ? (su_r - q_r[31:0]) : (su_r + q_r[31:0]);
      default: ;
    endcase
  end

  // output record register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) res_r <= rec;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  assign stat.short_cnt = cn_r < CNT_W'(2);
  assign stat.first_pt  = cnt_r == '0;
  assign stat.last_pt   = cnt_r >= segs;
  assign stat.zero_dir  = (ax_r == 33'd0) && (az_r == 33'd0);
  assign stat.norm_ok   = (m[32:31] == 2'b00) && m[30];
  assign stat.itr_zero  = itr_r == '0;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/rsvg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsvg_ctrl
// Sequencer that walks the datapath through one control point.
// ----------------------------------------------------------------------------
module rsvg_ctrl import rsvg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_CHECK = 18'h00002,
    S_NORM  = 18'h00004,
    S_SQB   = 18'h00008,
    S_SQRT  = 18'h00010,
    S_DIVX  = 18'h00020,
    S_DIVXS = 18'h00040,
    S_DIVZ  = 18'h00080,
    S_DIVZS = 18'h00100,
    S_NZ    = 18'h00200,
    S_OFFX  = 18'h00400,
    S_OFFZ  = 18'h00800,
    S_UMUL  = 18'h01000,
    S_UDIV  = 18'h02000,
    S_UDIVS = 18'h04000,
    S_USAVE = 18'h08000,
    S_EMIT  = 18'h10000,
    S_UPD   = 18'h20000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] beat_r, beat_nxt;
  logic       second_r, second_nxt;

  always_comb begin
    state_nxt  = state_r;
    beat_nxt   = beat_r;
    second_nxt = second_r;
    cmd        = '{op: OP_NONE, second: second_r, beat: beat_r, last: 1'b0};
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.short_cnt) begin
          cmd.op    = OP_CLEAR;
          state_nxt = S_IDLE;
        end else if (stat.first_pt) begin
          cmd.op    = OP_FIRST;
          state_nxt = S_IDLE;
        end else begin
          cmd.op     = OP_DIFF;
          beat_nxt   = 4'd0;
          second_nxt = 1'b0;
          state_nxt  = S_NORM;
        end
      end
      S_NORM: begin
        priority if (stat.zero_dir) begin
          cmd.op    = OP_ZERO;
          state_nxt = S_OFFX;
        end else if (stat.norm_ok) begin
          cmd.op    = OP_SQA;
          state_nxt = S_SQB;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SQB: begin
        cmd.op    = OP_SQB;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (stat.itr_zero) state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd.op    = OP_DIVX;
        state_nxt = S_DIVXS;
      end
      S_DIVXS: begin
        cmd.op = OP_DIVSTEP;
        if (stat.itr_zero) state_nxt = S_DIVZ;
      end
      S_DIVZ: begin
        cmd.op    = OP_DIVZ;
        state_nxt = S_DIVZS;
      end
      S_DIVZS: begin
        cmd.op = OP_DIVSTEP;
        if (stat.itr_zero) state_nxt = S_NZ;
      end
      S_NZ: begin
        cmd.op    = OP_NZ;
        state_nxt = S_OFFX;
      end
      S_OFFX: begin
        cmd.op    = OP_OFFX;
        state_nxt = S_OFFZ;
      end
      S_OFFZ: begin
        cmd.op    = OP_OFFZ;
        state_nxt = S_UMUL;
      end
      S_UMUL: begin
        cmd.op    = OP_UMUL;
        state_nxt = S_UDIV;
      end
      S_UDIV: begin
        cmd.op    = OP_UDIV;
        state_nxt = S_UDIVS;
      end
      S_UDIVS: begin
        cmd.op = OP_DIVSTEP;
        if (stat.itr_zero) state_nxt = S_USAVE;
      end
      S_USAVE: begin
        cmd.op    = OP_USAVE;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.last = ((beat_r == BEAT_IDX_HI) && !stat.last_pt) || (beat_r == BEAT_TAIL_HI);
        if (stat.out_free) begin
          cmd.op   = OP_EMIT;
          beat_nxt = beat_r + 4'd1;
          if (beat_r == BEAT_IDX_HI) begin
            if (stat.last_pt) begin
              // last point: offsets and u again for its own pair
              second_nxt = 1'b1;
              beat_nxt   = BEAT_TAIL_LO;
              state_nxt  = S_OFFX;
            end else begin
              state_nxt = S_UPD;
            end
          end else if (beat_r == BEAT_TAIL_HI) begin
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      beat_r   <= 4'd0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      beat_r   <= beat_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== rtl/ribbon_strip_vertex_generator_core.sv =====
// ----------------------------------------------------------------------------
// ribbon_strip_vertex_generator_core
// Extrudes ribbon control points into triangle strip vertex and index records.
// ----------------------------------------------------------------------------
// One control point is taken at a time. The first point of a ribbon, and any
// point of a ribbon shorter than two, emits nothing. Every later point goes
// through normalization and waits out any output stall; a vertical segment
// skips the square root and both normal divisions.
// It emits the left and right vertex of the previous point and six indices,
// and the last point also its own pair. Most of its work lies in the shared
// bit-serial divider (64 steps a division, three of them per point and a
// fourth for the last point) and the 32-step square root, both driven by one
// sequencer. The result register lets the next point be accepted while the
// final record still waits to be taken.
module ribbon_strip_vertex_generator_core import rsvg_pkg::*; #(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rsvg_in_if.sink      in_chan,
  rsvg_out_if.source   out_chan,
  rsvg_cfg_if.sink     cfg_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  point_t   in_pt;
  res_t     res;
  logic     in_ready;
  logic     out_valid;

  assign in_pt = '{point_x: in_chan.point_x, point_y: in_chan.point_y,
                   point_z: in_chan.point_z, half_width: in_chan.half_width,
                   point_color: in_chan.point_color, point_count: in_chan.point_count};

  assign in_chan.ready = in_ready;
  assign cfg_chan.ready = 1'b1;

  rsvg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsvg_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_pt     (in_pt),
    .cfg_we    (cfg_chan.valid),
    .cfg_idx   (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_res   (res),
    .stat      (stat)
  );

  assign out_chan.valid      = out_valid;
  assign out_chan.kind       = res.kind;
  assign out_chan.slot       = res.slot;
  assign out_chan.vert_x     = res.vert_x;
  assign out_chan.vert_y     = res.vert_y;
  assign out_chan.vert_z     = res.vert_z;
  assign out_chan.tex_u      = res.tex_u;
  assign out_chan.tex_v      = res.tex_v;
  assign out_chan.vert_color = res.vert_color;
  assign out_chan.vertex_ref = res.vertex_ref;
  assign out_chan.last       = res.last;

endmodule

// ===== rtl/rsvg_checker.sv =====
// ----------------------------------------------------------------------------
// rsvg_checker
// Port-level checks of the ribbon strip vertex generator, bound to the core.
// ----------------------------------------------------------------------------
module rsvg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic        out_last,
  input logic [31:0] out_slot,
  input logic [31:0] out_vert_x,
  input logic [31:0] out_tex_u,
  input logic [31:0] out_vert_color,
  input logic [31:0] out_vertex_ref
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_last))
    else $error("result beat changed while stalled");

  // one point at a time
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a point is in work");

  a_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |->
      out_vert_x == 32'd0 && out_tex_u == 32'd0 && out_vert_color == 32'd0)
    else $error("index record carries vertex data");

  a_vertex_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_vertex_ref == 32'd0)
    else $error("vertex record carries an index");

endmodule

bind ribbon_strip_vertex_generator_core rsvg_checker u_rsvg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_kind       (out_chan.kind),
  .out_last       (out_chan.last),
  .out_slot       (out_chan.slot),
  .out_vert_x     (out_chan.vert_x),
  .out_tex_u      (out_chan.tex_u),
  .out_vert_color (out_chan.vert_color),
  .out_vertex_ref (out_chan.vertex_ref)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// ribbon strip vertex generator testbench
// Feeds control points with random gaps and output stalls, predicts vertex and
// index records per point and checks each record field by field in order.
// ----------------------------------------------------------------------------
module tb_top import rsvg_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 1024;
  localparam int QUIET_LIMIT = 20000;

  logic clk;
  logic rst_n;

  rsvg_in_if  in_chan ();
  rsvg_out_if out_chan ();
  rsvg_cfg_if cfg_chan ();

  ribbon_strip_vertex_generator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_chan (cfg_chan.sink)
  );

  // predictor state
  logic [31:0] uv_su, uv_sv, uv_eu, uv_ev, vert_base, slot_base;
  logic [31:0] last_x, last_y, last_z, last_col;
  logic [30:0] last_hw;
  int unsigned pts_taken;

  point_t point_q[$];
  res_t   record_q[$];
  int     fails;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_cycles;
  int     quiet_cycles;
  bit     in_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] root64(input logic [63:0] s_in);
    logic [63:0] s, res, b;
    s = s_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // offset along the horizontal normal for direction (dx, dz)
  task automatic side_offset(input longint dx, input longint dz, input logic [30:0] w,
                             output longint ox, output longint oz);
    logic [63:0] ax, az, m, len, nx, nz, offx, offz;
    ax = dx < 0 ? -dx : dx;
    az = dz < 0 ? -dz : dz;
    ox = 0;
    oz = 0;
    m = ax > az ? ax : az;
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin
        m = m >> 1; ax = ax >> 1; az = az >> 1;
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1; ax = ax << 1; az = az << 1;
      end
      len = root64(ax * ax + az * az);
      nx = (az << 30) / len;
      nz = (ax << 30) / len;
      offx = (nx * w + (64'd1 << 29)) >> 30;
      offz = (nz * w + (64'd1 << 29)) >> 30;
      ox = dz > 0 ? -longint'(offx) : longint'(offx);
      oz = dx < 0 ? -longint'(offz) : longint'(offz);
    end
  endtask

  function automatic logic [31:0] tex_u_at(input int unsigned k_in, input int unsigned segs);
    longint us, diff;
    logic [63:0] mag, q;
    int unsigned k;
    k = k_in > segs ? segs : k_in;
    us = longint'(signed'(uv_su));
    diff = longint'(signed'(uv_eu)) - us;
    mag = (diff < 0 ? -diff : diff) * k;
    q = (2 * mag + segs) / (2 * 64'(segs));
    return diff < 0 ? 32'(us - longint'(q)) : 32'(us + longint'(q));
  endfunction

  task automatic push_pair(input int unsigned k, input int unsigned segs, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz, input longint ox,
                           input longint oz, input logic [31:0] col);
    res_t r;
    r = '0;
    r.tex_u = tex_u_at(k, segs);
    r.vert_y = py;
    r.vert_color = col;
    r.slot = vert_base + 32'(2 * k);
    r.vert_x = clip32(longint'(signed'(px)) - ox);
    r.vert_z = clip32(longint'(signed'(pz)) - oz);
    r.tex_v = uv_sv;
    record_q = {record_q, r};
    r.slot = r.slot + 1;
    r.vert_x = clip32(longint'(signed'(px)) + ox);
    r.vert_z = clip32(longint'(signed'(pz)) + oz);
    r.tex_v = uv_ev;
    record_q = {record_q, r};
  endtask

  task automatic predict_point(input point_t p);
    int unsigned n, i, segs;
    longint dx, dz, ox, oz;
    res_t r;
    n = p.point_count > MAXP ? MAXP : p.point_count;
    if (n < 2) begin
      pts_taken = 0;
      return;
    end
    if (pts_taken == 0) begin
      last_x = p.point_x; last_y = p.point_y; last_z = p.point_z;
      last_hw = p.half_width; last_col = p.point_color;
      pts_taken = 1;
      return;
    end
    i = pts_taken;
    segs = n - 1;
    dx = longint'(signed'(p.point_x)) - longint'(signed'(last_x));
    dz = longint'(signed'(p.point_z)) - longint'(signed'(last_z));
    side_offset(dx, dz, last_hw, ox, oz);
    push_pair(i - 1, segs, last_x, last_y, last_z, ox, oz, last_col);
    for (int j = 0; j < 6; j++) begin
      r = '0;
      r.kind = 1'b1;
      r.slot = slot_base + 32'(6 * (i - 1) + j);
      r.vertex_ref = vert_base + 32'(2 * (i - 1)) + 32'(tri_ofs(3'(j)));
      record_q = {record_q, r};
    end
    if (i >= segs) begin
      side_offset(dx, dz, p.half_width, ox, oz);
      push_pair(i, segs, p.point_x, p.point_y, p.point_z, ox, oz, p.point_color);
      pts_taken = 0;
    end else begin
      last_x = p.point_x; last_y = p.point_y; last_z = p.point_z;
      last_hw = p.half_width; last_col = p.point_color;
      pts_taken = i + 1;
    end
    record_q[$].last = 1'b1;
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !in_taken) begin
      // hold the beat
    end else if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_chan.valid       <= 1'b1;
      in_chan.point_x     <= point_q[0].point_x;
      in_chan.point_y     <= point_q[0].point_y;
      in_chan.point_z     <= point_q[0].point_z;
      in_chan.half_width  <= point_q[0].half_width;
      in_chan.point_color <= point_q[0].point_color;
      in_chan.point_count <= point_q[0].point_count;
      void'(point_q.pop_front());
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_chan.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // input acceptance drives the predictor
  always @(posedge clk) begin
    in_taken <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      predict_point('{point_x: in_chan.point_x, point_y: in_chan.point_y,
                      point_z: in_chan.point_z, half_width: in_chan.half_width,
                      point_color: in_chan.point_color, point_count: in_chan.point_count});
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (record_q.size() == 0) begin
        $error("unexpected record slot=%h", out_chan.slot);
        fails++;
      end else begin
        e = record_q.pop_front();
        if (out_chan.kind !== e.kind) begin
          $error("kind exp %h got %h", e.kind, out_chan.kind); fails++;
        end
        if (out_chan.slot !== e.slot) begin
          $error("slot exp %h got %h", e.slot, out_chan.slot); fails++;
        end
        if (out_chan.vert_x !== e.vert_x) begin
          $error("vert_x exp %h got %h", e.vert_x, out_chan.vert_x); fails++;
        end
        if (out_chan.vert_y !== e.vert_y) begin
          $error("vert_y exp %h got %h", e.vert_y, out_chan.vert_y); fails++;
        end
        if (out_chan.vert_z !== e.vert_z) begin
          $error("vert_z exp %h got %h", e.vert_z, out_chan.vert_z); fails++;
        end
        if (out_chan.tex_u !== e.tex_u) begin
          $error("tex_u exp %h got %h", e.tex_u, out_chan.tex_u); fails++;
        end
        if (out_chan.tex_v !== e.tex_v) begin
          $error("tex_v exp %h got %h", e.tex_v, out_chan.tex_v); fails++;
        end
        if (out_chan.vert_color !== e.vert_color) begin
          $error("vert_color exp %h got %h", e.vert_color, out_chan.vert_color); fails++;
        end
        if (out_chan.vertex_ref !== e.vertex_ref) begin
          $error("vertex_ref exp %h got %h", e.vertex_ref, out_chan.vertex_ref); fails++;
        end
        if (out_chan.last !== e.last) begin
          $error("last exp %h got %h", e.last, out_chan.last); fails++;
        end
      end
    end
  end

  // watchdog on beats
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    case (idx)
      CFG_UV_START_U: uv_su = val;
      CFG_UV_START_V: uv_sv = val;
      CFG_UV_END_U:   uv_eu = val;
      CFG_UV_END_V:   uv_ev = val;
      CFG_BASE_VERT:  vert_base = val;
      CFG_BASE_SLOT:  slot_base = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (point_q.size() > 0 || in_chan.valid || record_q.size() > 0) @(posedge clk);
    // a point that emits nothing may still be in work
    repeat (400) @(posedge clk);
  endtask

  function automatic point_t rand_point(input int unsigned cnt);
    point_t p;
    p.point_x = $urandom;
    p.point_y = $urandom;
    p.point_z = $urandom;
    p.half_width = 31'($urandom);
    p.point_color = $urandom;
    p.point_count = 11'(cnt);
    // keep most coordinates near each other for realistic shapes
    if ($urandom_range(3) != 0) begin
      p.point_x = 32'(signed'(32'($urandom_range(20'hfffff))) - 32'sh80000);
      p.point_z = 32'(signed'(32'($urandom_range(20'hfffff))) - 32'sh80000);
      p.half_width = 31'($urandom_range(32'h3ffff));
    end
    return p;
  endfunction

  task automatic queue_ribbon(input int unsigned cnt, input int unsigned pts);
    for (int k = 0; k < pts; k++) point_q = {point_q, rand_point(cnt)};
  endtask

  task automatic set_regs(input logic [31:0] su, input logic [31:0] sv, input logic [31:0] eu,
                          input logic [31:0] ev, input logic [31:0] bv, input logic [31:0] bs);
    write_reg(CFG_UV_START_U, su);
    write_reg(CFG_UV_START_V, sv);
    write_reg(CFG_UV_END_U, eu);
    write_reg(CFG_UV_END_V, ev);
    write_reg(CFG_BASE_VERT, bv);
    write_reg(CFG_BASE_SLOT, bs);
  endtask

  task automatic random_phase(input int items);
    int sent;
    int unsigned n, pts;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin n = $urandom_range(1); pts = 1; end
        1: begin n = $urandom_range(2047); pts = $urandom_range(1, 4); end
        default: begin n = $urandom_range(2, 6); pts = n; end
      endcase
      queue_ribbon(n, pts);
      sent += pts;
    end
    wait_drained();
  endtask

  initial begin
    point_t p;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.point_x = '0; in_chan.point_y = '0; in_chan.point_z = '0;
    in_chan.half_width = '0; in_chan.point_color = '0; in_chan.point_count = '0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0; cfg_chan.index = '0; cfg_chan.data = '0;
    uv_su = 0; uv_sv = 0; uv_eu = 32'd65536; uv_ev = 32'd65536;
    vert_base = 0; slot_base = 0;
    last_x = 0; last_y = 0; last_z = 0; last_hw = 0; last_col = 0; pts_taken = 0;
    fails = 0; hold_cycles = 0; quiet_cycles = 0;
    send_idle_pct = 13; recv_idle_pct = 60;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, vertical segment, saturation, short and oversize counts
    p = '{point_x: 32'h7fffffff, point_y: 32'h80000000, point_z: 32'h80000000,
          half_width: 31'h7fffffff, point_color: 32'hffffffff, point_count: 11'd3};
    point_q = {point_q, p};
    p.point_x = 32'h80000000; p.point_z = 32'h7fffffff; p.point_color = 0;
    point_q = {point_q, p};
    p.half_width = 0; p.point_y = 32'h7fffffff;
    point_q = {point_q, p};
    p = '{point_x: 32'h10000, point_y: 0, point_z: 32'h10000, half_width: 31'h10000,
          point_color: 32'h12345678, point_count: 11'd2};
    point_q = {point_q, p};
    p.point_y = 32'h50000;
    point_q = {point_q, p};
    p.point_count = 11'd0; point_q = {point_q, p};
    p.point_count = 11'd1; point_q = {point_q, p};
    p.point_count = 11'd2047; point_q = {point_q, p};
    p.point_x = 32'h20000; point_q = {point_q, p};
    p.point_count = 11'd3; point_q = {point_q, p};
    queue_ribbon(11'd1024, 2);
    queue_ribbon(11'd2, 2);
    queue_ribbon(11'd5, 2);
    queue_ribbon(11'd4, 3);
    wait_drained();

    set_regs(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
             32'hfffffffe, 32'hfffffffc);
    random_phase(60);

    // long receiver hold-off so the block backs up its input
    hold_cycles = 3000;
    random_phase(20);

    set_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_idle_pct = 60; recv_idle_pct = 13;
    random_phase(100);

    set_regs(32'h7fffffff, 0, 32'h80000000, 32'hffffffff, 0, 32'hffffffff);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(100);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
